// ----- hdl/sid_pkg.sv -----
package sid_pkg;

    // Coordinate and arithmetic widths.
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = CROSS_W;
    localparam int Q_W        = 32;
    localparam int SHIFT_W    = Q_W - FRAC_BITS;
    localparam int OV_W       = MAG_W + SHIFT_W;
    localparam int S_DATA_W   = ((8 * COORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = 2 * Q_W;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_MISS     = 2'd1,
        ST_PARALLEL = 2'd2
    } status_t;

    // One division lane as it moves down the cell row.
    typedef struct packed {
        logic [MAG_W-1:0] un;
        logic [MAG_W-1:0] ud;
        logic [MAG_W-1:0] rem;
        logic [Q_W-1:0]   quo;
    } div_lane_t;

    // Side information that travels with both lanes.
    typedef struct packed {
        logic hit;
        logic par;
        logic neg_a;
        logic neg_b;
        logic ovf_a;
        logic ovf_b;
    } div_meta_t;

endpackage

// ----- hdl/segment_intersection_top.sv -----
// Segment intersection: each transfer on the input stream carries two line
// segments as eight signed integer end points; each result transfer gives the
// status (hit, miss or parallel) on m_tuser and both segment parameters as
// signed Q15.16, truncated toward zero and saturated, on m_tdata. A new pair
// is taken in every cycle while the result side does not stall. There are 37
// register stages: front stages for differences, cross products, determinants
// and magnitudes, then a row of 32 divider cells that each resolve one
// quotient bit of both parameters, then the output register. A stall on the
// result side holds the whole pipeline.
module segment_intersection_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y from the lowest bit up
    input  logic [sid_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // along_first, along_second from the lowest bit up
    output logic [sid_pkg::M_DATA_W-1:0]  m_tdata,
    // status
    output logic [1:0]                    m_tuser
);
    import sid_pkg::*;

    localparam int C = COORD_BITS;

    logic en;

    logic v0_reg, v1_reg, v2_reg, v3_reg, m_valid_reg;

    logic signed [DIFF_W-1:0]  ex_reg, ey_reg, fx_reg, fy_reg, gx_reg, gy_reg;
    logic signed [PROD_W-1:0]  fyex_reg, fxey_reg, fygx_reg, fxgy_reg, eygx_reg, exgy_reg;
    logic signed [CROSS_W-1:0] d_reg, na_reg, nb_reg;
    logic [MAG_W-1:0]          ud_reg, ua_reg, ub_reg;
    div_meta_t                 meta3_reg, meta4;
    div_lane_t                 lane_a4, lane_b4;
    logic [Q_W-1:0]            first_reg, second_reg;
    status_t                   status_reg;

    logic signed [DIFF_W-1:0]  x1, y1, x2, y2, x3, y3, x4, y4;

    // The whole pipeline moves whenever the output register can take a result.
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // Sign-extended coordinates.
    assign x1 = DIFF_W'($signed(s_tdata[0*C +: C]));
    assign y1 = DIFF_W'($signed(s_tdata[1*C +: C]));
    assign x2 = DIFF_W'($signed(s_tdata[2*C +: C]));
    assign y2 = DIFF_W'($signed(s_tdata[3*C +: C]));
    assign x3 = DIFF_W'($signed(s_tdata[4*C +: C]));
    assign y3 = DIFF_W'($signed(s_tdata[5*C +: C]));
    assign x4 = DIFF_W'($signed(s_tdata[6*C +: C]));
    assign y4 = DIFF_W'($signed(s_tdata[7*C +: C]));

    // Valid bits of the front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Edge vectors, cross products and the three determinants.
    always_ff @(posedge aclk) begin
        if (en) begin
            ex_reg <= x2 - x1;
            ey_reg <= y2 - y1;
            fx_reg <= x4 - x3;
            fy_reg <= y4 - y3;
            gx_reg <= x3 - x1;
            gy_reg <= y3 - y1;

            fyex_reg <= fy_reg * ex_reg;
            fxey_reg <= fx_reg * ey_reg;
            fygx_reg <= fy_reg * gx_reg;
            fxgy_reg <= fx_reg * gy_reg;
            eygx_reg <= ey_reg * gx_reg;
            exgy_reg <= ex_reg * gy_reg;

            d_reg  <= CROSS_W'(fyex_reg) - CROSS_W'(fxey_reg);
            na_reg <= CROSS_W'(fygx_reg) - CROSS_W'(fxgy_reg);
            nb_reg <= CROSS_W'(eygx_reg) - CROSS_W'(exgy_reg);
        end
    end

    // Magnitudes, signs and the exact test against the segment ends.
    always_ff @(posedge aclk) begin
        if (en) begin
            ud_reg <= d_reg[CROSS_W-1]  ? MAG_W'(-d_reg)  : MAG_W'(d_reg);
            ua_reg <= na_reg[CROSS_W-1] ? MAG_W'(-na_reg) : MAG_W'(na_reg);
            ub_reg <= nb_reg[CROSS_W-1] ? MAG_W'(-nb_reg) : MAG_W'(nb_reg);
            meta3_reg.par   <= (d_reg == '0);
            meta3_reg.neg_a <= na_reg[CROSS_W-1] ^ d_reg[CROSS_W-1];
            meta3_reg.neg_b <= nb_reg[CROSS_W-1] ^ d_reg[CROSS_W-1];
            if (d_reg > 0) begin
                meta3_reg.hit <= (na_reg >= 0) && (na_reg <= d_reg)
                              && (nb_reg >= 0) && (nb_reg <= d_reg);
            end else begin
                meta3_reg.hit <= (na_reg <= 0) && (na_reg >= d_reg)
                              && (nb_reg <= 0) && (nb_reg >= d_reg);
            end
            meta3_reg.ovf_a <= 1'b0;
            meta3_reg.ovf_b <= 1'b0;
        end
    end

    // Quotient overflow check and initial partial remainder, fed to the first cell.
    always_comb begin
        meta4       = meta3_reg;
        meta4.ovf_a = OV_W'(ua_reg) >= {ud_reg, {SHIFT_W{1'b0}}};
        meta4.ovf_b = OV_W'(ub_reg) >= {ud_reg, {SHIFT_W{1'b0}}};
        lane_a4     = '{un: ua_reg, ud: ud_reg, rem: ua_reg >> SHIFT_W, quo: '0};
        lane_b4     = '{un: ub_reg, ud: ud_reg, rem: ub_reg >> SHIFT_W, quo: '0};
    end

    // Row of divider cells, one quotient bit each, most significant first.
    logic      cv   [0:Q_W];
    div_lane_t ca   [0:Q_W];
    div_lane_t cb   [0:Q_W];
    div_meta_t cm   [0:Q_W];

    assign cv[0] = v3_reg;
    assign ca[0] = lane_a4;
    assign cb[0] = lane_b4;
    assign cm[0] = meta4;

    for (genvar i = 0; i < Q_W; i++) begin : g_cell
        localparam int K = Q_W - 1 - i;
        logic nbit_a, nbit_b;
        if (K >= FRAC_BITS) begin : g_bit
            assign nbit_a = ca[i].un[K-FRAC_BITS];
            assign nbit_b = cb[i].un[K-FRAC_BITS];
        end else begin : g_zero
            assign nbit_a = 1'b0;
            assign nbit_b = 1'b0;
        end
        sid_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cv[i]),
            .in_a      (ca[i]),
            .in_b      (cb[i]),
            .in_meta   (cm[i]),
            .nbit_a    (nbit_a),
            .nbit_b    (nbit_b),
            .out_valid (cv[i+1]),
            .out_a     (ca[i+1]),
            .out_b     (cb[i+1]),
            .out_meta  (cm[i+1])
        );
    end

    // Saturate and apply the sign.
    function automatic logic [Q_W-1:0] finish(input logic [Q_W-1:0] q,
                                              input logic neg, input logic ovf);
        logic [Q_W-1:0] lim;
        logic [Q_W-1:0] qs;
        lim = neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        qs  = (ovf || (q > lim)) ? lim : q;
        return neg ? -qs : qs;
    endfunction

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cv[Q_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (cm[Q_W].par) begin
                status_reg <= ST_PARALLEL;
                first_reg  <= '0;
                second_reg <= '0;
            end else begin
                status_reg <= cm[Q_W].hit ? ST_HIT : ST_MISS;
                first_reg  <= finish(ca[Q_W].quo, cm[Q_W].neg_a, cm[Q_W].ovf_a);
                second_reg <= finish(cb[Q_W].quo, cm[Q_W].neg_b, cm[Q_W].ovf_b);
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {second_reg, first_reg};
    assign m_tuser  = status_reg;

endmodule

// ----- hdl/sid_cell.sv -----
module sid_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  sid_pkg::div_lane_t in_a,
    input  sid_pkg::div_lane_t in_b,
    input  sid_pkg::div_meta_t in_meta,
    input  logic              nbit_a,
    input  logic              nbit_b,
    output logic              out_valid,
    output sid_pkg::div_lane_t out_a,
    output sid_pkg::div_lane_t out_b,
    output sid_pkg::div_meta_t out_meta
);
    import sid_pkg::*;

    logic      valid_reg;
    div_lane_t a_reg, a_next;
    div_lane_t b_reg, b_next;
    div_meta_t meta_reg;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    function automatic div_lane_t step(input div_lane_t l, input logic nbit);
        logic [MAG_W:0] t;
        div_lane_t      o;
        t = {l.rem, nbit};
        o = l;
        if (t >= {1'b0, l.ud}) begin
            t = t - {1'b0, l.ud};
            o.quo = {l.quo[Q_W-2:0], 1'b1};
        end else begin
            o.quo = {l.quo[Q_W-2:0], 1'b0};
        end
        o.rem = t[MAG_W-1:0];
        return o;
    endfunction

    always_comb begin
        a_next = step(in_a, nbit_a);
        b_next = step(in_b, nbit_b);
    end

    // Valid bit of this cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Payload of this cell.
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            meta_reg <= in_meta;
        end
    end

    assign out_valid = valid_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_meta  = meta_reg;

endmodule

// ----- dv/segment_intersection_top_tb.sv -----
`timescale 1ns / 1ps

module segment_intersection_top_tb;
    import sid_pkg::*;

    localparam int PIPE_LATENCY = 37;
    localparam int NUM_RANDOM   = 550;

    // One decoded result: status and both parameters.
    typedef struct {
        status_t           status;
        logic signed [31:0] along_first;
        logic signed [31:0] along_second;
    } isect_result_t;

    // Magnitude helper on 64-bit values.
    function automatic longint unsigned abs64(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Truncated, saturated fixed-point quotient n/d.
    function automatic logic [31:0] quotient_q(input longint n, input longint d);
        longint unsigned un, ud, qi, rem, frac, q, lim;
        bit neg;
        un = abs64(n);
        ud = abs64(d);
        neg = (n < 0) != (d < 0);
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (ud == 0) return '0;
        qi = un / ud;
        rem = un % ud;
        if (qi > (64'h8000_0000 >> FRAC_BITS))
            return neg ? 32'(-longint'(lim)) : 32'(lim);
        frac = 0;
        for (int i = 0; i < FRAC_BITS; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= ud) begin
                rem = rem - ud;
                frac = frac | 1;
            end
        end
        q = (qi << FRAC_BITS) | frac;
        if (q > lim) q = lim;
        return neg ? 32'(-longint'(q)) : 32'(q);
    endfunction

    function automatic bit within_unit(input longint n, input longint d);
        if (d > 0) return n >= 0 && n <= d;
        return n <= 0 && n >= d;
    endfunction

    // Predicts the result of one segment pair.
    function automatic isect_result_t intersect_segments(input logic [S_DATA_W-1:0] data);
        longint c[8];
        longint ex, ey, fx, fy, gx, gy, den, na, nb;
        isect_result_t r;
        for (int i = 0; i < 8; i++)
            c[i] = longint'($signed(data[i*COORD_BITS +: COORD_BITS]));
        ex = c[2] - c[0]; ey = c[3] - c[1];
        fx = c[6] - c[4]; fy = c[7] - c[5];
        gx = c[4] - c[0]; gy = c[5] - c[1];
        den = fy * ex - fx * ey;
        if (den == 0) begin
            r.status = ST_PARALLEL;
            r.along_first = 0;
            r.along_second = 0;
            return r;
        end
        na = fy * gx - fx * gy;
        nb = ey * gx - ex * gy;
        r.along_first = quotient_q(na, den);
        r.along_second = quotient_q(nb, den);
        r.status = (within_unit(na, den) && within_unit(nb, den)) ? ST_HIT : ST_MISS;
        return r;
    endfunction

    // Holds the predicted results in order and compares arrivals with them.
    class isect_scoreboard;
        isect_result_t pending[$];
        int errors;
        int checked;

        function void note_pair(input logic [S_DATA_W-1:0] data);
            pending.push_back(intersect_segments(data));
        endfunction

        function void check_result(input logic [1:0] user, input logic [M_DATA_W-1:0] data);
            isect_result_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d data=%h", $realtime, user, data);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (user !== exp_r.status) begin
                $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status, user);
                errors++;
            end
            if (data[31:0] !== exp_r.along_first) begin
                $display("%0t: along_first expected %h actual %h", $realtime,
                         exp_r.along_first, data[31:0]);
                errors++;
            end
            if (data[63:32] !== exp_r.along_second) begin
                $display("%0t: along_second expected %h actual %h", $realtime,
                         exp_r.along_second, data[63:32]);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;

    isect_scoreboard sb = new();
    bit   sending_done = 1'b0;
    int   n_parallel, n_hit, n_miss;

    segment_intersection_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Coordinates: mostly small, sometimes full range or an extreme.
    function automatic logic [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
            1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
            2, 3, 4: return COORD_BITS'($urandom);
            default: return COORD_BITS'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    // Drives one pair and waits for its transfer; valid stays high afterwards.
    task automatic send_pair(input logic [S_DATA_W-1:0] data);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_pair(data);
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    function automatic logic [S_DATA_W-1:0] pack8(input int v[8]);
        logic [S_DATA_W-1:0] d;
        d = '0;
        for (int i = 0; i < 8; i++) d[i*COORD_BITS +: COORD_BITS] = COORD_BITS'(v[i]);
        return d;
    endfunction

    function automatic logic [S_DATA_W-1:0] random_pair();
        logic [S_DATA_W-1:0] d;
        int v[8];
        int k;
        d = '0;
        case ($urandom_range(0, 5))
            0: begin
                // Parallel: second direction a multiple of the first.
                for (int i = 0; i < 6; i++) v[i] = int'($urandom_range(0, 200)) - 100;
                k = int'($urandom_range(0, 6)) - 3;
                v[6] = v[4] + k * (v[2] - v[0]);
                v[7] = v[5] + k * (v[3] - v[1]);
                d = pack8(v);
            end
            default:
                for (int i = 0; i < 8; i++) d[i*COORD_BITS +: COORD_BITS] = pick_coord();
        endcase
        return d;
    endfunction

    // Result side: random back-pressure, checks every transfer.
    initial begin : sink
        int stall;
        @(posedge aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tuser, m_tdata);
            case (m_tuser)
                ST_PARALLEL: n_parallel++;
                ST_HIT:      n_hit++;
                default:     n_miss++;
            endcase
        end
    end

    // Stimulus.
    initial begin : source
        int mx, mn;
        mx = 8388607;
        mn = -8388608;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: crossing, miss, parallel, collinear, degenerate, extremes.
        send_pair(pack8('{0, 0, 10, 10, 0, 10, 10, 0}));
        send_pair(pack8('{0, 0, 10, 0, 0, 0, 0, 10}));
        send_pair(pack8('{0, 0, 10, 10, 20, 0, 30, 30}));
        send_pair(pack8('{0, 0, 10, 0, 0, 5, 10, 5}));
        send_pair(pack8('{0, 0, 10, 0, 5, 0, 20, 0}));
        send_pair(pack8('{3, 3, 3, 3, 1, 2, 7, 9}));
        send_pair(pack8('{0, 0, 2, 0, 1, -1, 1, 1}));
        send_pair(pack8('{0, 0, 1, 0, 1000000, -1, 1000000, 1}));
        send_pair(pack8('{0, 0, 1, 0, -1000000, -1, -1000000, 1}));
        send_pair(pack8('{0, 0, 10, 0, 10, -5, 10, 5}));
        send_pair(pack8('{0, 0, 10, 0, 11, -5, 11, 5}));
        send_pair(pack8('{0, 0, 10, 0, -1, -5, -1, 5}));
        send_pair(pack8('{mn, mn, mx, mx, mn, mx, mx, mn}));
        send_pair(pack8('{mx, mx, mn, mn, mx, mn, mn, mx}));
        send_pair(pack8('{mn, mn, mn, mx, mx, mn, mx, mx}));
        send_pair(pack8('{mn, 0, mx, 1, 0, mn, 1, mx}));
        send_pair(pack8('{0, 0, 1, 0, mn, mn, mx, mx}));
        send_pair(pack8('{0, 0, 0, 1, mx, mn, mn, mx}));
        send_pair({S_DATA_W{1'b1}});
        send_pair({(S_DATA_W/2){2'b10}});
        // Let the pipeline drain once before the random part.
        drain();
        for (int i = 0; i < NUM_RANDOM; i++) begin
            send_pair(random_pair());
            if (i == NUM_RANDOM / 2) begin
                drain();
            end
        end
        drain();
        repeat (PIPE_LATENCY + 10) @(posedge aclk);
        $display("Checked %0d results: %0d hit, %0d miss, %0d parallel.",
                 sb.checked, n_hit, n_miss, n_parallel);
        $display("Directed extremes, parallel and collinear cases, then random pairs.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Timeout guard.
    initial begin : watchdog
        #5_000_000;
        $display("Timeout waiting for results.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sid_pkg.sv
hdl/sid_cell.sv
hdl/segment_intersection_top.sv
dv/segment_intersection_top_tb.sv
